FILE: rtl/u8dc_pkg.sv
package u8dc_pkg;

    // field widths
    localparam int unsigned CpWidth  = 21;
    localparam int unsigned LenWidth = 3;

    // lead byte patterns
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Code = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Code = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Code = 8'hF0;

    // sequence lengths
    localparam logic [LenWidth-1:0] Len1 = 3'd1;
    localparam logic [LenWidth-1:0] Len2 = 3'd2;
    localparam logic [LenWidth-1:0] Len3 = 3'd3;
    localparam logic [LenWidth-1:0] Len4 = 3'd4;

    // class range bounds
    localparam logic [CpWidth-1:0] DigitLo     = 21'h00030;
    localparam logic [CpWidth-1:0] DigitHi     = 21'h00039;
    localparam logic [CpWidth-1:0] AsciiHi     = 21'h0007F;
    localparam logic [CpWidth-1:0] UpperLo     = 21'h00041;
    localparam logic [CpWidth-1:0] UpperHi     = 21'h0005A;
    localparam logic [CpWidth-1:0] LowerLo     = 21'h00061;
    localparam logic [CpWidth-1:0] LowerHi     = 21'h0007A;
    localparam logic [CpWidth-1:0] LatinLo     = 21'h000C0;
    localparam logic [CpWidth-1:0] LatinHi     = 21'h0017F;
    localparam logic [CpWidth-1:0] Times       = 21'h000D7;
    localparam logic [CpWidth-1:0] Divide      = 21'h000F7;
    localparam logic [CpWidth-1:0] ExtLo       = 21'h00180;
    localparam logic [CpWidth-1:0] ExtHi       = 21'h002AF;
    localparam logic [CpWidth-1:0] GreekLo     = 21'h00370;
    localparam logic [CpWidth-1:0] GreekHi     = 21'h003FF;
    localparam logic [CpWidth-1:0] GkSignLo    = 21'h00374;
    localparam logic [CpWidth-1:0] GkSignHi    = 21'h00375;
    localparam logic [CpWidth-1:0] GkQuestLo   = 21'h0037E;
    localparam logic [CpWidth-1:0] GkQuestHi   = 21'h0037F;
    localparam logic [CpWidth-1:0] GkTonosLo   = 21'h00384;
    localparam logic [CpWidth-1:0] GkTonosHi   = 21'h00385;
    localparam logic [CpWidth-1:0] GkAnoTeleia = 21'h00387;
    localparam logic [CpWidth-1:0] CyrLo       = 21'h00400;
    localparam logic [CpWidth-1:0] CyrHi       = 21'h004FF;
    localparam logic [CpWidth-1:0] ArmLo       = 21'h00531;
    localparam logic [CpWidth-1:0] ArmHi       = 21'h0058F;
    localparam logic [CpWidth-1:0] RunicLo     = 21'h016A0;
    localparam logic [CpWidth-1:0] RunicHi     = 21'h016F8;
    localparam logic [CpWidth-1:0] HiraLo      = 21'h03040;
    localparam logic [CpWidth-1:0] HiraHi      = 21'h03096;
    localparam logic [CpWidth-1:0] KanaLo      = 21'h03099;
    localparam logic [CpWidth-1:0] KanaHi      = 21'h030FF;
    localparam logic [CpWidth-1:0] EmojiALo    = 21'h1F300;
    localparam logic [CpWidth-1:0] EmojiAHi    = 21'h1F64F;
    localparam logic [CpWidth-1:0] EmojiBLo    = 21'h1F680;
    localparam logic [CpWidth-1:0] EmojiBHi    = 21'h1F6C5;
    localparam logic [CpWidth-1:0] EmojiCLo    = 21'h1F900;
    localparam logic [CpWidth-1:0] EmojiCHi    = 21'h1F9FF;
    localparam logic [CpWidth-1:0] EmojiDLo    = 21'h1FA70;
    localparam logic [CpWidth-1:0] EmojiDHi    = 21'h1FAFF;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    // decoded character
    typedef struct packed {
        logic [CpWidth-1:0]  cp;
        logic [LenWidth-1:0] len;
    } decoded_t;

    // raw range hits, combined in the last stage
    typedef struct packed {
        logic digit;
        logic ascii;
        logic upper;
        logic lower;
        logic latin;
        logic latin_excl;
        logic ext;
        logic greek;
        logic greek_excl;
        logic cyr;
        logic arm;
        logic runic;
        logic hira;
        logic kana;
        logic emoji_a;
        logic emoji_b;
        logic emoji_c;
        logic emoji_d;
    } range_hits_t;

    // final class flags
    typedef struct packed {
        logic digit;
        logic ascii;
        logic letter;
        logic emoji;
    } class_flags_t;

    function automatic logic in_range(
        input logic [CpWidth-1:0] v,
        input logic [CpWidth-1:0] lo,
        input logic [CpWidth-1:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

FILE: rtl/utf8_decode_and_classify_unit.sv
// UTF-8 character decoder and classifier.
// Input channel: in_valid / in_stall carry up to four bytes of one character
// and the count of bytes present. A transfer happens when in_valid is high
// and in_stall is low.
// Output channel: out_valid / out_stall carry the code point, the bytes
// consumed and the digit, ascii, letter and emoji flags.
// Stages: an input transfer passes through the decode stage, the range
// compare stage and the flag combine stage, which also holds the output.
// Throughput while out_stall is low: one character per cycle; each of the
// three stages takes a new item whenever it is empty or its contents move
// on in the same cycle.
// Receiver stall: the output stage holds its item, earlier stages fill their
// empty slots, and in_stall rises only once all three stages are full.
// Reset clears the stage valid bits; the pipeline comes up empty and ready.
module utf8_decode_and_classify_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  lead_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic [7:0]  fourth_byte,
    input  logic [2:0]  bytes_available,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [2:0]  byte_count,
    output logic        is_digit,
    output logic        is_ascii,
    output logic        is_letter,
    output logic        is_emoji
);

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic adv1;
    logic adv2;
    logic adv3;

    u8dc_pkg::pipe_en_t     en;
    u8dc_pkg::decoded_t     dec1;
    u8dc_pkg::decoded_t     dec3;
    u8dc_pkg::class_flags_t flags;

    // a stage loads when it is empty or its item moves on
    assign adv3 = !v3_reg || !out_stall;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign en.s1 = adv1;
    assign en.s2 = adv2;
    assign en.s3 = adv3;

    assign in_stall = !adv1;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    u8dc_decode u_decode (
        .clk             (clk),
        .en              (en),
        .lead_byte       (lead_byte),
        .second_byte     (second_byte),
        .third_byte      (third_byte),
        .fourth_byte     (fourth_byte),
        .bytes_available (bytes_available),
        .dec             (dec1)
    );

    u8dc_classify u_classify (
        .clk     (clk),
        .en      (en),
        .dec     (dec1),
        .dec_out (dec3),
        .flags   (flags)
    );

    // output transfer
    assign out_valid  = v3_reg;
    assign code_point = dec3.cp;
    assign byte_count = dec3.len;
    assign is_digit   = flags.digit;
    assign is_ascii   = flags.ascii;
    assign is_letter  = flags.letter;
    assign is_emoji   = flags.emoji;

endmodule

FILE: rtl/u8dc_decode.sv
module u8dc_decode (
    input  logic                clk,
    input  u8dc_pkg::pipe_en_t  en,
    input  logic [7:0]          lead_byte,
    input  logic [7:0]          second_byte,
    input  logic [7:0]          third_byte,
    input  logic [7:0]          fourth_byte,
    input  logic [2:0]          bytes_available,
    output u8dc_pkg::decoded_t  dec
);

    u8dc_pkg::decoded_t dec_next;
    u8dc_pkg::decoded_t dec_reg;

    // lead byte pattern and byte count pick the sequence form
    always_comb
    begin
        priority if (!lead_byte[7])
        begin
            dec_next.cp  = {13'd0, lead_byte};
            dec_next.len = u8dc_pkg::Len1;
        end
        else if (((lead_byte & u8dc_pkg::Lead2Mask) == u8dc_pkg::Lead2Code)
                 && (bytes_available >= 3'd2))
        begin
            dec_next.cp  = {10'd0, lead_byte[4:0], second_byte[5:0]};
            dec_next.len = u8dc_pkg::Len2;
        end
        else if (((lead_byte & u8dc_pkg::Lead3Mask) == u8dc_pkg::Lead3Code)
                 && (bytes_available >= 3'd3))
        begin
            dec_next.cp  = {5'd0, lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
            dec_next.len = u8dc_pkg::Len3;
        end
        else if (((lead_byte & u8dc_pkg::Lead4Mask) == u8dc_pkg::Lead4Code)
                 && (bytes_available >= 3'd4))
        begin
            dec_next.cp  = {lead_byte[2:0], second_byte[5:0], third_byte[5:0],
                            fourth_byte[5:0]};
            dec_next.len = u8dc_pkg::Len4;
        end
        else
        begin
            // invalid or short sequence: raw lead byte
            dec_next.cp  = {13'd0, lead_byte};
            dec_next.len = u8dc_pkg::Len1;
        end
    end

    // stage 1 register
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule

FILE: rtl/u8dc_classify.sv
module u8dc_classify (
    input  logic                   clk,
    input  u8dc_pkg::pipe_en_t     en,
    input  u8dc_pkg::decoded_t     dec,
    output u8dc_pkg::decoded_t     dec_out,
    output u8dc_pkg::class_flags_t flags
);

    u8dc_pkg::range_hits_t  hits_next;
    u8dc_pkg::range_hits_t  hits_reg;
    u8dc_pkg::decoded_t     dec2_reg;
    u8dc_pkg::decoded_t     dec3_reg;
    u8dc_pkg::class_flags_t flags_next;
    u8dc_pkg::class_flags_t flags_reg;
    logic [u8dc_pkg::CpWidth-1:0] c;

    assign c = dec.cp;

    // range compares
    always_comb
    begin
        hits_next.digit      = u8dc_pkg::in_range(c, u8dc_pkg::DigitLo, u8dc_pkg::DigitHi);
        hits_next.ascii      = (c <= u8dc_pkg::AsciiHi);
        hits_next.upper      = u8dc_pkg::in_range(c, u8dc_pkg::UpperLo, u8dc_pkg::UpperHi);
        hits_next.lower      = u8dc_pkg::in_range(c, u8dc_pkg::LowerLo, u8dc_pkg::LowerHi);
        hits_next.latin      = u8dc_pkg::in_range(c, u8dc_pkg::LatinLo, u8dc_pkg::LatinHi);
        hits_next.latin_excl = (c == u8dc_pkg::Times) || (c == u8dc_pkg::Divide);
        hits_next.ext        = u8dc_pkg::in_range(c, u8dc_pkg::ExtLo, u8dc_pkg::ExtHi);
        hits_next.greek      = u8dc_pkg::in_range(c, u8dc_pkg::GreekLo, u8dc_pkg::GreekHi);
        hits_next.greek_excl =
            u8dc_pkg::in_range(c, u8dc_pkg::GkSignLo, u8dc_pkg::GkSignHi)
            || u8dc_pkg::in_range(c, u8dc_pkg::GkQuestLo, u8dc_pkg::GkQuestHi)
            || u8dc_pkg::in_range(c, u8dc_pkg::GkTonosLo, u8dc_pkg::GkTonosHi)
            || (c == u8dc_pkg::GkAnoTeleia);
        hits_next.cyr        = u8dc_pkg::in_range(c, u8dc_pkg::CyrLo, u8dc_pkg::CyrHi);
        hits_next.arm        = u8dc_pkg::in_range(c, u8dc_pkg::ArmLo, u8dc_pkg::ArmHi);
        hits_next.runic      = u8dc_pkg::in_range(c, u8dc_pkg::RunicLo, u8dc_pkg::RunicHi);
        hits_next.hira       = u8dc_pkg::in_range(c, u8dc_pkg::HiraLo, u8dc_pkg::HiraHi);
        hits_next.kana       = u8dc_pkg::in_range(c, u8dc_pkg::KanaLo, u8dc_pkg::KanaHi);
        hits_next.emoji_a    = u8dc_pkg::in_range(c, u8dc_pkg::EmojiALo, u8dc_pkg::EmojiAHi);
        hits_next.emoji_b    = u8dc_pkg::in_range(c, u8dc_pkg::EmojiBLo, u8dc_pkg::EmojiBHi);
        hits_next.emoji_c    = u8dc_pkg::in_range(c, u8dc_pkg::EmojiCLo, u8dc_pkg::EmojiCHi);
        hits_next.emoji_d    = u8dc_pkg::in_range(c, u8dc_pkg::EmojiDLo, u8dc_pkg::EmojiDHi);
    end

    // stage 2 register
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            hits_reg <= hits_next;
            dec2_reg <= dec;
        end
    end

    // combine hits; the letter ranges do not overlap
    always_comb
    begin
        flags_next.digit  = hits_reg.digit;
        flags_next.ascii  = hits_reg.ascii;
        flags_next.letter = hits_reg.upper || hits_reg.lower
                            || (hits_reg.latin && !hits_reg.latin_excl)
                            || hits_reg.ext
                            || (hits_reg.greek && !hits_reg.greek_excl)
                            || hits_reg.cyr || hits_reg.arm || hits_reg.runic
                            || hits_reg.hira || hits_reg.kana;
        flags_next.emoji  = hits_reg.emoji_a || hits_reg.emoji_b
                            || hits_reg.emoji_c || hits_reg.emoji_d;
    end

    // stage 3 register, drives the output
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            flags_reg <= flags_next;
            dec3_reg  <= dec2_reg;
        end
    end

    assign dec_out = dec3_reg;
    assign flags   = flags_reg;

endmodule

FILE: dv/utf8_char_checker.sv
module utf8_char_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  lead_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic [7:0]  fourth_byte,
    input  logic [2:0]  bytes_available,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [20:0] code_point,
    input  logic [2:0]  byte_count,
    input  logic        is_digit,
    input  logic        is_ascii,
    input  logic        is_letter,
    input  logic        is_emoji,
    output int          fail_count,
    output int          pending
);

    // one decoded and classified character
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  len;
        logic        digit;
        logic        ascii;
        logic        letter;
        logic        emoji;
    } char_info_t;

    // characters accepted on the input, oldest first
    char_info_t expected_chars[$];

    function automatic logic in_span(
        input logic [20:0] v,
        input logic [20:0] lo,
        input logic [20:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

    // latin, ipa, greek, cyrillic, armenian, runic and kana blocks
    function automatic logic letter_cp(input logic [20:0] c);
        return in_span(c, 'h41, 'h5A) || in_span(c, 'h61, 'h7A)
            || (in_span(c, 'hC0, 'h17F) && c != 'hD7 && c != 'hF7)
            || in_span(c, 'h180, 'h2AF)
            || (in_span(c, 'h370, 'h3FF) && !in_span(c, 'h374, 'h375)
                && !in_span(c, 'h37E, 'h37F) && !in_span(c, 'h384, 'h385)
                && c != 'h387)
            || in_span(c, 'h400, 'h4FF) || in_span(c, 'h531, 'h58F)
            || in_span(c, 'h16A0, 'h16F8)
            || in_span(c, 'h3040, 'h3096) || in_span(c, 'h3099, 'h30FF);
    endfunction

    function automatic logic emoji_cp(input logic [20:0] c);
        return in_span(c, 'h1F300, 'h1F64F) || in_span(c, 'h1F680, 'h1F6C5)
            || in_span(c, 'h1F900, 'h1F9FF) || in_span(c, 'h1FA70, 'h1FAFF);
    endfunction

    // decode one character and flag its classes
    function automatic char_info_t decode_char(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] n
    );
        int unsigned avail;
        char_info_t  r;
        // zero count means the lead byte alone, above four means four
        avail = (n == 0) ? 1 : (n > 4) ? 4 : n;
        r.cp  = {13'd0, b0};
        r.len = 3'd1;
        if (b0[7:5] == 3'b110 && avail >= 2) begin
            r.cp  = {10'd0, b0[4:0], b1[5:0]};
            r.len = 3'd2;
        end
        else if (b0[7:4] == 4'b1110 && avail >= 3) begin
            r.cp  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            r.len = 3'd3;
        end
        else if (b0[7:3] == 5'b11110 && avail >= 4) begin
            r.cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            r.len = 3'd4;
        end
        r.digit  = in_span(r.cp, 'h30, 'h39);
        r.ascii  = r.cp <= 'h7F;
        r.letter = letter_cp(r.cp);
        r.emoji  = emoji_cp(r.cp);
        return r;
    endfunction

    task automatic check_field(
        input string       field,
        input logic [20:0] want,
        input logic [20:0] got,
        inout int          bad
    );
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            bad++;
        end
    endtask

    // compare each output transfer, then record each input transfer
    always @(posedge clk) begin
        char_info_t want;
        int         bad;
        if (!rst_n) begin
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            bad = 0;
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("output transfer with nothing expected: code_point %h",
                           code_point);
                    bad++;
                end
                else begin
                    want = expected_chars.pop_front();
                    check_field("code_point", want.cp, code_point, bad);
                    check_field("byte_count", want.len, byte_count, bad);
                    check_field("is_digit", want.digit, is_digit, bad);
                    check_field("is_ascii", want.ascii, is_ascii, bad);
                    check_field("is_letter", want.letter, is_letter, bad);
                    check_field("is_emoji", want.emoji, is_emoji, bad);
                end
            end
            if (in_valid && !in_stall)
                expected_chars.push_back(decode_char(lead_byte, second_byte, third_byte,
                                                     fourth_byte, bytes_available));
            fail_count <= fail_count + bad;
            pending    <= expected_chars.size();
        end
    end

endmodule

FILE: dv/tb_utf8_decode_and_classify_unit.sv
module tb_utf8_decode_and_classify_unit;

    localparam int ItemsPerPhase = 600;
    localparam int StallLimit    = 2000;
    localparam int HoldCycles    = 60;
    localparam int DrainCycles   = 12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  lead_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
    logic [7:0]  fourth_byte;
    logic [2:0]  bytes_available;
    logic        out_valid;
    logic        out_stall;
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        is_digit;
    logic        is_ascii;
    logic        is_letter;
    logic        is_emoji;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int phase;
    int idle_cycles;

    // code points at every class boundary, some with a neighbour outside it
    int unsigned class_bounds[$] = '{
        'h2F, 'h30, 'h39, 'h3A, 'h40, 'h41, 'h5A, 'h5B, 'h60, 'h61, 'h7A, 'h7B,
        'h7F, 'h80, 'hBF, 'hC0, 'hD7, 'hF7, 'h17F, 'h180, 'h2AF, 'h2B0, 'h36F,
        'h370, 'h374, 'h375, 'h37E, 'h37F, 'h384, 'h385, 'h387, 'h3FF, 'h400,
        'h4FF, 'h500, 'h530, 'h531, 'h58F, 'h590, 'h16A0, 'h16F8, 'h3040,
        'h3096, 'h3099, 'h30FF, 'h1F300, 'h1F64F, 'h1F680, 'h1F6C5, 'h1F900,
        'h1F9FF, 'h1FA70, 'h1FAFF
    };

    utf8_decode_and_classify_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .lead_byte       (lead_byte),
        .second_byte     (second_byte),
        .third_byte      (third_byte),
        .fourth_byte     (fourth_byte),
        .bytes_available (bytes_available),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .code_point      (code_point),
        .byte_count      (byte_count),
        .is_digit        (is_digit),
        .is_ascii        (is_ascii),
        .is_letter       (is_letter),
        .is_emoji        (is_emoji)
    );

    utf8_char_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .lead_byte       (lead_byte),
        .second_byte     (second_byte),
        .third_byte      (third_byte),
        .fourth_byte     (fourth_byte),
        .bytes_available (bytes_available),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .code_point      (code_point),
        .byte_count      (byte_count),
        .is_digit        (is_digit),
        .is_ascii        (is_ascii),
        .is_letter       (is_letter),
        .is_emoji        (is_emoji),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // continuation byte, usually with the proper 10 prefix
    function automatic logic [7:0] cont_byte(input logic [5:0] payload);
        logic [1:0] prefix;
        prefix = ($urandom_range(9) < 8) ? 2'b10 : 2'($urandom);
        return {prefix, payload};
    endfunction

    // utf-8 form of a code point at a given length, unused bytes random
    function automatic void encode_char(
        input  int unsigned cp,
        input  int unsigned len,
        output logic [7:0]  b0,
        output logic [7:0]  b1,
        output logic [7:0]  b2,
        output logic [7:0]  b3
    );
        logic [20:0] v;
        v = cp[20:0];
        {b0, b1, b2, b3} = $urandom;
        case (len)
            1: b0 = {1'b0, v[6:0]};
            2:
            begin
                b0 = {3'b110, v[10:6]};
                b1 = cont_byte(v[5:0]);
            end
            3:
            begin
                b0 = {4'b1110, v[15:12]};
                b1 = cont_byte(v[11:6]);
                b2 = cont_byte(v[5:0]);
            end
            default:
            begin
                b0 = {5'b11110, v[20:18]};
                b1 = cont_byte(v[17:12]);
                b2 = cont_byte(v[11:6]);
                b3 = cont_byte(v[5:0]);
            end
        endcase
    endfunction

    // offer one character, entered and left at a falling edge
    task automatic send_char(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] n
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            {lead_byte, second_byte, third_byte, fourth_byte} <= $urandom;
            bytes_available <= 3'($urandom);
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        lead_byte       <= b0;
        second_byte     <= b1;
        third_byte      <= b2;
        fourth_byte     <= b3;
        bytes_available <= n;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // mostly well-formed characters, many near class edges, some cut short, some noise
    task automatic send_random_char();
        int unsigned pick;
        int unsigned cp;
        int unsigned len;
        int unsigned min_len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [2:0]  n;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            if (pick < 50)
                cp = class_bounds[$urandom_range(class_bounds.size() - 1)]
                     + $urandom_range(4) - 2;
            else
            begin
                case ($urandom_range(3))
                    0: cp = $urandom_range('h7F);
                    1: cp = $urandom_range('h7FF);
                    2: cp = $urandom_range('hFFFF);
                    default: cp = $urandom_range('h1FFFFF);
                endcase
            end
            min_len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            // overlong forms now and then
            len = ($urandom_range(4) == 0) ? $urandom_range(4, min_len) : min_len;
            encode_char(cp, len, b0, b1, b2, b3);
            n = ($urandom_range(3) == 0) ? 3'($urandom_range(7, len)) : 3'(len);
        end
        else if (pick < 90)
        begin
            // multibyte lead with too few bytes behind it
            len = $urandom_range(4, 2);
            encode_char($urandom_range('h1FFFFF), len, b0, b1, b2, b3);
            n = 3'($urandom_range(len - 1, 0));
        end
        else
        begin
            {b0, b1, b2, b3} = $urandom;
            n = 3'($urandom_range(7));
        end
        send_char(b0, b1, b2, b3, n);
    endtask

    // receiver: a long hold at the start of each idling phase, then random stalls
    initial
    begin
        int hold_left;
        int held_phase;
        hold_left  = 0;
        held_phase = -1;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && phase != held_phase)
            begin
                held_phase = phase;
                hold_left  = (phase < 2) ? HoldCycles : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit)
        begin
            $display("FAIL utf8_decode_and_classify_unit");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and verdict
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        lead_byte       = 8'h00;
        second_byte     = 8'h00;
        third_byte      = 8'h00;
        fourth_byte     = 8'h00;
        bytes_available = 3'd1;
        phase           = 0;
        tx_idle_pct     = 17;
        rx_idle_pct     = 48;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ascii extremes and digits
        send_char(8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
        send_char(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd1);
        send_char(8'h30, 8'h80, 8'h80, 8'h80, 3'd4);
        send_char(8'h39, 8'h00, 8'h00, 8'h00, 3'd2);
        // two-byte forms: letter, times sign, top value, overlong digit, greek punctuation
        send_char(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2);
        send_char(8'hC3, 8'h97, 8'h00, 8'h00, 3'd2);
        send_char(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd2);
        send_char(8'hC0, 8'hB5, 8'h00, 8'h00, 3'd3);
        send_char(8'hCD, 8'hBE, 8'h00, 8'h00, 3'd2);
        send_char(8'hCE, 8'h87, 8'h00, 8'h00, 3'd2);
        // three-byte forms: runic, kana, surrogate, top value
        send_char(8'hE1, 8'h9A, 8'hA0, 8'h00, 3'd3);
        send_char(8'hE3, 8'h82, 8'h99, 8'h00, 3'd3);
        send_char(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
        send_char(8'hEF, 8'hBF, 8'hBF, 8'hBF, 3'd4);
        // four-byte forms: emoji and the top of the range
        send_char(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4);
        send_char(8'hF0, 8'h9F, 8'hAA, 8'hB0, 3'd4);
        send_char(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4);
        // short sequences fall back to the raw lead byte
        send_char(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1);
        send_char(8'hE3, 8'h82, 8'h99, 8'h00, 3'd2);
        send_char(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3);
        send_char(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd3);
        // bad lead bytes
        send_char(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
        send_char(8'hF8, 8'h88, 8'h80, 8'h80, 3'd4);
        send_char(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
        // count of zero and counts above four
        send_char(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd0);
        send_char(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7);
        send_char(8'hE1, 8'h9A, 8'hA0, 8'h00, 3'd5);

        // receiver idles more, then sender more, then neither
        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 17 : (p == 1) ? 48 : 0;
            rx_idle_pct <= (p == 0) ? 48 : (p == 1) ? 17 : 0;
            phase       <= p;
            repeat (ItemsPerPhase) send_random_char();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("PASS utf8_decode_and_classify_unit");
        else
            $display("FAIL utf8_decode_and_classify_unit");
        $finish;
    end

endmodule
